// File: src/rmsec_pkg.sv
// Package for the windowed RMS envelope correlation block.
// Payload types, FSM codes and arithmetic constants; no dependencies.
`default_nettype none

package rmsec_pkg;

    localparam int unsigned MAX_WINDOWS = 65536;
    localparam logic [16:0] MAX_WIN     = 17'(MAX_WINDOWS);
    localparam logic [15:0] WL_RESET    = 16'd1024;
    localparam logic [16:0] CORR_ONE    = 17'd32768;
    localparam logic [63:0] SQRT_TOP    = 64'h4000_0000_0000_0000;
    // divide steps = 64 dividend bits + 15 fraction bits + both exponents (stored +1)
    localparam logic [7:0]  CDIV_BASE   = 8'd77;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_CAPPED = 2'd2;

    typedef struct packed {
        logic signed [15:0] a_left;
        logic signed [15:0] a_right;
        logic signed [15:0] b_left;
        logic signed [15:0] b_right;
        logic               end_of_stream;
    } t_frame;

    typedef struct packed {
        logic [15:0] correlation;
        logic [16:0] windows_used;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_SQA, S_SQB, S_WDIV, S_SQRT, S_PAB, S_PAA, S_PBB,
        S_CHECK, S_NORM, S_MULD, S_CDIV, S_EMIT
    } t_state;

    // what the shared square root is working on
    typedef enum logic [1:0] {
        PH_WA, PH_WB, PH_CA, PH_CB
    } t_phase;

endpackage

`default_nettype wire

// File: src/rmsec_if.sv
// Valid/ready channel interfaces for frames, results and the config write.
// Depends on rmsec_pkg for the payload types.
`default_nettype none

interface rmsec_frame_if;
    import rmsec_pkg::*;
    logic   valid;
    logic   ready;
    t_frame data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmsec_result_if;
    import rmsec_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmsec_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/rms_envelope_correlation.sv
// Top level: windowed RMS envelope correlation of two stereo streams.
// Depends on rmsec_pkg and the channel interfaces in rmsec_if.sv.
//
//  channel   dir  payload                                       request when
//  i_frame   in   a_left a_right b_left b_right end_of_stream   valid & ready
//  o_result  out  correlation windows_used status               valid & ready
//  i_cfg     in   window_length (16 bit)                        valid & ready
//
// A frame request starts SQA then SQB; no new frame is taken until the block is
// back in IDLE. A closing window adds a divide and a root per stream on the
// shared subtractor, then the PAB, PAA and PBB multiplies. End of stream adds a
// normalize and root per sum of squares, a multiply and the correlation divide.
// Reset (synchronous, low) clears all sums and sets window_length to 1024.
// The frame side is ready only between requests; a finished result sits in
// the output register and the next frame is taken while it waits.
`default_nettype none

module rms_envelope_correlation (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rmsec_frame_if.sink   i_frame,
    rmsec_result_if.source o_result,
    rmsec_cfg_if.sink     i_cfg
);
    import rmsec_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [15:0] r_wl;
    logic [49:0] r_ea, r_eb;
    logic [15:0] r_fiw;
    logic [16:0] r_wc;
    logic [63:0] r_cs, r_sa, r_sb;
    logic        r_cap;
    logic [16:0] r_ma, r_mb;
    logic        r_eos;
    logic [63:0] r_x, r_r, r_bit, r_d;
    logic [64:0] r_rem;
    logic [31:0] r_ra, r_rb;
    logic [4:0]  r_ee, r_eea, r_eeb;
    logic [7:0]  r_cnt, r_tot;
    logic [16:0] r_q;
    logic        r_sat;
    logic [15:0] r_corr;
    logic [1:0]  r_stat;
    logic        r_ov;
    t_result     r_res;

    logic [15:0] w_eff;
    logic [15:0] n_fiw;
    logic        accept, emit_go;
    logic signed [16:0] mono_a, mono_b;

    // shared multiplier and subtractor
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [64:0] op_a, op_b, diff;
    logic        ge;
    logic [64:0] rem_sh;
    logic [63:0] sq_sum, root_next;
    logic [17:0] q_next;
    logic        q_over;

    assign w_eff  = (r_wl == 16'd0) ? 16'd1 : r_wl;
    assign n_fiw  = r_fiw + 16'd1;
    assign accept = i_frame.valid && i_frame.ready;
    assign emit_go = (r_state == S_EMIT) && (!r_ov || o_result.ready);

    assign i_frame.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_result.valid = r_ov;
    assign o_result.data  = r_res;

    assign mono_a = 17'(i_frame.data.a_left) + 17'(i_frame.data.a_right);
    assign mono_b = 17'(i_frame.data.b_left) + 17'(i_frame.data.b_right);

    // multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_state)
            S_SQA:   begin mul_a = 32'(r_ma); mul_b = 32'(r_ma); end
            S_SQB:   begin mul_a = 32'(r_mb); mul_b = 32'(r_mb); end
            S_PAB,
            S_MULD:  begin mul_a = r_ra; mul_b = r_rb; end
            S_PAA:   begin mul_a = r_ra; mul_b = r_ra; end
            S_PBB:   begin mul_a = r_rb; mul_b = r_rb; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // subtractor operand select: restoring divide step or root step
    assign rem_sh = {r_rem[63:0], r_x[63]};
    assign sq_sum = r_r + r_bit;
    always_comb begin
        op_a = 65'd0;
        op_b = 65'd0;
        unique case (r_state)
            S_WDIV:  begin op_a = rem_sh; op_b = 65'(w_eff); end
            S_CDIV:  begin op_a = rem_sh; op_b = {1'b0, r_d}; end
            S_SQRT:  begin op_a = {1'b0, r_x}; op_b = {1'b0, sq_sum}; end
            default: begin op_a = 65'd0; op_b = 65'd0; end
        endcase
    end
    assign diff = op_a - op_b;
    assign ge   = !diff[64];
    assign root_next = ge ? ((r_r >> 1) + r_bit) : (r_r >> 1);

    // correlation quotient with sticky saturation
    assign q_next = {r_q, ge};
    assign q_over = r_sat || (q_next > 18'(CORR_ONE));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_SQA;
            S_SQA:   n_state = S_SQB;
            S_SQB:   n_state = (n_fiw >= w_eff) ? S_WDIV : S_CHECK;
            S_WDIV:  if (r_cnt == 8'd63) n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == 8'd31) begin
                    unique case (r_phase)
                        PH_WA: n_state = S_WDIV;
                        PH_WB: n_state = (r_wc >= MAX_WIN) ? S_CHECK : S_PAB;
                        PH_CA: n_state = S_NORM;
                        PH_CB: n_state = S_MULD;
                    endcase
                end
            end
            S_PAB:   n_state = S_PAA;
            S_PAA:   n_state = S_PBB;
            S_PBB:   n_state = S_CHECK;
            S_CHECK: begin
                priority if (!r_eos)                       n_state = S_IDLE;
                else if (r_sa == 64'd0 || r_sb == 64'd0)   n_state = S_EMIT;
                else                                       n_state = S_NORM;
            end
            S_NORM:  if (r_x[63:60] != 4'd0) n_state = S_SQRT;
            S_MULD:  n_state = S_CDIV;
            S_CDIV:  if (r_cnt == r_tot - 8'd1) n_state = S_EMIT;
            S_EMIT:  if (emit_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl  <= WL_RESET;
            r_ea  <= '0;
            r_eb  <= '0;
            r_fiw <= '0;
            r_wc  <= '0;
            r_cs  <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
            r_cap <= 1'b0;
            r_ov  <= 1'b0;
            r_phase <= PH_WA;
        end else begin
            if (i_cfg.valid) r_wl <= i_cfg.data;
            if (o_result.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_SQA: r_ea <= r_ea + prod[49:0];
                S_SQB: begin
                    r_eb <= r_eb + prod[49:0];
                    if (n_fiw >= w_eff) begin
                        r_fiw   <= '0;
                        r_phase <= PH_WA;
                    end else begin
                        r_fiw <= n_fiw;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 8'd31) begin
                        unique case (r_phase)
                            PH_WA: r_phase <= PH_WB;
                            PH_WB: begin
                                r_ea <= '0;
                                r_eb <= '0;
                                if (r_wc >= MAX_WIN) r_cap <= 1'b1;
                            end
                            PH_CA: r_phase <= PH_CB;
                            PH_CB: r_phase <= PH_CB;
                        endcase
                    end
                end
                S_PAB: r_cs <= r_cs + prod;
                S_PAA: r_sa <= r_sa + prod;
                S_PBB: begin
                    r_sb <= r_sb + prod;
                    r_wc <= r_wc + 17'd1;
                end
                S_CHECK: r_phase <= PH_CA;
                S_EMIT: begin
                    if (emit_go) begin
                        r_ov  <= 1'b1;
                        r_ea  <= '0;
                        r_eb  <= '0;
                        r_fiw <= '0;
                        r_wc  <= '0;
                        r_cs  <= '0;
                        r_sa  <= '0;
                        r_sb  <= '0;
                        r_cap <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_ma  <= mono_a[16] ? 17'(-mono_a) : 17'(mono_a);
                    r_mb  <= mono_b[16] ? 17'(-mono_b) : 17'(mono_b);
                    r_eos <= i_frame.data.end_of_stream;
                end
            end
            S_SQB: begin
                // energy_a is final here; start its window divide
                r_x   <= {r_ea, 14'd0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_WDIV: begin
                r_rem <= ge ? diff : rem_sh;
                r_x   <= {r_x[62:0], ge};
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd63) begin
                    r_r   <= '0;
                    r_bit <= SQRT_TOP;
                    r_cnt <= '0;
                end
            end
            S_SQRT: begin
                if (ge) r_x <= diff[63:0];
                r_r   <= root_next;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd31) begin
                    r_cnt <= '0;
                    unique case (r_phase)
                        PH_WA: begin
                            r_ra  <= root_next[31:0];
                            r_x   <= {r_eb, 14'd0};
                            r_rem <= '0;
                        end
                        PH_WB: r_rb <= root_next[31:0];
                        PH_CA: begin
                            r_ra <= root_next[31:0];
                            // normalize square_sum_b
                            if (r_sb[63:62] != 2'd0) begin
                                r_x  <= r_sb >> 2;
                                r_ee <= 5'd0;
                            end else begin
                                r_x  <= r_sb;
                                r_ee <= 5'd1;
                            end
                        end
                        PH_CB: r_rb <= root_next[31:0];
                    endcase
                end
            end
            S_CHECK: begin
                r_corr <= '0;
                r_stat <= ST_ZERO;
                // normalize square_sum_a
                if (r_sa[63:62] != 2'd0) begin
                    r_x  <= r_sa >> 2;
                    r_ee <= 5'd0;
                end else begin
                    r_x  <= r_sa;
                    r_ee <= 5'd1;
                end
            end
            S_NORM: begin
                if (r_x[63:60] == 4'd0) begin
                    r_x  <= r_x << 2;
                    r_ee <= r_ee + 5'd1;
                end else begin
                    if (r_phase == PH_CA) r_eea <= r_ee;
                    else                  r_eeb <= r_ee;
                    r_r   <= '0;
                    r_bit <= SQRT_TOP;
                    r_cnt <= '0;
                end
            end
            S_MULD: begin
                r_d   <= prod;
                r_x   <= r_cs;
                r_rem <= '0;
                r_q   <= '0;
                r_sat <= 1'b0;
                r_cnt <= '0;
                r_tot <= CDIV_BASE + 8'(r_eea) + 8'(r_eeb);
            end
            S_CDIV: begin
                r_rem <= ge ? diff : rem_sh;
                r_x   <= {r_x[62:0], 1'b0};
                r_cnt <= r_cnt + 8'd1;
                r_sat <= q_over;
                if (!q_over) r_q <= q_next[16:0];
                if (r_cnt == r_tot - 8'd1) begin
                    r_corr <= q_over ? CORR_ONE[15:0] : q_next[15:0];
                    r_stat <= r_cap ? ST_CAPPED : ST_OK;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    r_res.correlation  <= r_corr;
                    r_res.windows_used <= r_wc;
                    r_res.status       <= r_stat;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_res.correlation <= CORR_ONE[15:0]))
        else $error("correlation above one");
    a_zero_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.status == ST_ZERO) |-> (r_res.correlation == 16'd0))
        else $error("zero status with nonzero correlation");
    a_win_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= MAX_WIN)
        else $error("window count past cap");
    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> (r_wc == 17'd0 && r_fiw == 16'd0 && !r_cap))
        else $error("state not cleared after result");

endmodule

`default_nettype wire

// File: test/rms_envelope_correlation_test.sv
// Testbench for rms_envelope_correlation: random and directed stereo frame streams,
// with results checked against a cycle-free predictor of the block.
// Depends on rmsec_pkg and the channel interfaces in rmsec_if.sv.
`timescale 1ns / 1ps

module rms_envelope_correlation_test;
    import rmsec_pkg::*;

    localparam int QUIET_CYCLES = 600;   // longest window close or end-of-stream work, with margin
    localparam int HOLD_CYCLES  = 3000;  // long receiver stall

    typedef struct {
        bit          is_cfg;
        logic [15:0] wlen;
        t_frame      frame;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    rmsec_frame_if  frm ();
    rmsec_result_if res ();
    rmsec_cfg_if    cfg ();

    rms_envelope_correlation uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frm.sink),
        .o_result (res.source),
        .i_cfg    (cfg.sink)
    );

    // stimulus and expected correlation results
    t_pending pending_q[$];
    t_result  corr_q[$];
    int       errors;
    int       frames_taken;
    int       quiet;
    bit       hold_done;
    int       hold_left;

    // predictor state
    logic [15:0]       p_wlen;
    logic [49:0]       p_energy_a, p_energy_b;
    logic [15:0]       p_frames;
    logic [16:0]       p_windows;
    longint unsigned   p_cross, p_sq_a, p_sq_b;
    bit                p_capped;

    // clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mono_power(logic signed [15:0] l, logic signed [15:0] r);
        logic signed [16:0] m;
        longint unsigned mag;
        m = 17'(l) + 17'(r);
        mag = (m < 0) ? longint'(-m) : longint'(m);
        return mag * mag;
    endfunction

    // scaled root: sqrt(x) ~ r * 2^-e
    function automatic longint unsigned scaled_root(longint unsigned x, output int e);
        int n, k;
        longint unsigned y;
        n = 0;
        while (n < 64 && (x >> n) != 0) n++;
        k = 62 - n;
        if (k % 2 != 0) k = k - 1;
        y = (k >= 0) ? (x << k) : (x >> (-k));
        e = k / 2;
        return int_sqrt(y);
    endfunction

    function automatic logic [15:0] norm_correlation();
        int ea, eb, t;
        longint unsigned ra, rb, d, q, rem;
        ra = scaled_root(p_sq_a, ea);
        rb = scaled_root(p_sq_b, eb);
        d = ra * rb;
        if (d == 0) return 16'(CORR_ONE);
        q = p_cross / d;
        rem = p_cross % d;
        if (q > CORR_ONE) return 16'(CORR_ONE);
        t = ea + eb + 15;
        for (int i = 0; i < t; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q = q | 1;
            end
            if (q > CORR_ONE) return 16'(CORR_ONE);
        end
        return 16'(q);
    endfunction

    task automatic clear_envelope();
        p_energy_a = '0; p_energy_b = '0;
        p_frames = '0; p_windows = '0;
        p_cross = 0; p_sq_a = 0; p_sq_b = 0;
        p_capped = 0;
    endtask

    // advance the predictor by one frame, queue a result on end of stream
    task automatic predict_frame(t_frame f);
        longint unsigned w, ra, rb;
        t_result r;
        w = (p_wlen == 0) ? 1 : p_wlen;
        p_energy_a = p_energy_a + 50'(mono_power(f.a_left, f.a_right));
        p_energy_b = p_energy_b + 50'(mono_power(f.b_left, f.b_right));
        p_frames = p_frames + 16'd1;
        if (p_frames >= w) begin
            ra = int_sqrt((64'(p_energy_a) << 14) / w);
            rb = int_sqrt((64'(p_energy_b) << 14) / w);
            p_energy_a = '0; p_energy_b = '0; p_frames = '0;
            if (p_windows >= MAX_WIN) begin
                p_capped = 1;
            end else begin
                p_cross += ra * rb;
                p_sq_a += ra * ra;
                p_sq_b += rb * rb;
                p_windows++;
            end
        end
        if (f.end_of_stream) begin
            if (p_sq_a == 0 || p_sq_b == 0) begin
                r.correlation = '0;
                r.status = ST_ZERO;
            end else begin
                r.correlation = norm_correlation();
                r.status = p_capped ? ST_CAPPED : ST_OK;
            end
            r.windows_used = p_windows;
            corr_q.push_back(r);
            clear_envelope();
        end
    endtask

    // idle percentage per stage of the run
    function automatic int sender_idle_pct();
        if (frames_taken < 240) return 25;
        if (frames_taken < 480) return 53;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (frames_taken < 240) return 53;
        if (frames_taken < 480) return 25;
        return 0;
    endfunction

    // frame and config driver
    always @(posedge i_clk) begin
        bit f_valid, c_valid;
        t_frame f_data;
        logic [15:0] c_data;
        f_valid = frm.valid;
        f_data = frm.data;
        c_valid = cfg.valid;
        c_data = cfg.data;
        if (!i_rst_n) begin
            f_valid = 0;
            c_valid = 0;
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (frm.valid && frm.ready) begin
                predict_frame(frm.data);
                frames_taken++;
                quiet = 0;
                f_valid = 0;
            end
            if (res.valid && res.ready) quiet = 0;
            if (cfg.valid && cfg.ready) begin
                p_wlen = cfg.data;
                c_valid = 0;
            end
            if (!f_valid && !c_valid && pending_q.size() > 0) begin
                if (pending_q[0].is_cfg) begin
                    // register write only once the block has gone idle
                    if (corr_q.size() == 0 && quiet >= QUIET_CYCLES) begin
                        c_valid = 1;
                        c_data = pending_q[0].wlen;
                        void'(pending_q.pop_front());
                    end
                end else if ($urandom_range(99) >= sender_idle_pct()) begin
                    f_valid = 1;
                    f_data = pending_q[0].frame;
                    void'(pending_q.pop_front());
                end
            end
        end
        frm.valid <= f_valid;
        frm.data <= f_data;
        cfg.valid <= c_valid;
        cfg.data <= c_data;
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_result want;
        bit rdy;
        rdy = 0;
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (corr_q.size() == 0) begin
                    $error("result with nothing expected: %p", res.data);
                    errors++;
                end else begin
                    want = corr_q.pop_front();
                    if (res.data.correlation !== want.correlation) begin
                        $error("correlation expected %0d actual %0d",
                               want.correlation, res.data.correlation);
                        errors++;
                    end
                    if (res.data.windows_used !== want.windows_used) begin
                        $error("windows_used expected %0d actual %0d",
                               want.windows_used, res.data.windows_used);
                        errors++;
                    end
                    if (res.data.status !== want.status) begin
                        $error("status expected %0d actual %0d",
                               want.status, res.data.status);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up into the frame side
            if (!hold_done && frames_taken >= 150) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                rdy = ($urandom_range(99) >= receiver_idle_pct());
            end
        end
        res.ready <= rdy;
    end

    task automatic add_frame(int al, int ar, int bl, int br, bit eos);
        t_pending p;
        p.is_cfg = 0;
        p.wlen = '0;
        p.frame.a_left = 16'(al);
        p.frame.a_right = 16'(ar);
        p.frame.b_left = 16'(bl);
        p.frame.b_right = 16'(br);
        p.frame.end_of_stream = eos;
        pending_q.push_back(p);
    endtask

    task automatic add_cfg(int wl);
        t_pending p;
        p.is_cfg = 1;
        p.wlen = 16'(wl);
        p.frame = '0;
        pending_q.push_back(p);
    endtask

    function automatic int sample_at(int amp);
        if ($urandom_range(9) == 0) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2 * amp)) - amp;
    endfunction

    // random streams: windows with a random envelope per stream
    task automatic add_streams(int nframes, int wl);
        int left, len, amp_a, amp_b;
        left = nframes;
        while (left > 0) begin
            len = $urandom_range(1, 4 * ((wl == 0) ? 1 : wl) + 3);
            if (len > left) len = left;
            left -= len;
            for (int i = 0; i < len; i++) begin
                if (i % ((wl == 0) ? 1 : wl) == 0) begin
                    amp_a = $urandom_range(32767);
                    // correlated, anti-correlated or unrelated envelopes
                    case ($urandom_range(2))
                        0: amp_b = amp_a;
                        1: amp_b = 32767 - amp_a;
                        default: amp_b = $urandom_range(32767);
                    endcase
                end
                add_frame(sample_at(amp_a), sample_at(amp_a), sample_at(amp_b),
                          sample_at(amp_b), (i == len - 1) && ($urandom_range(9) != 0));
            end
        end
        add_frame(sample_at(1000), sample_at(1000), sample_at(500), sample_at(500), 1);
    endtask

    initial begin
        int wl_list[6];
        wl_list = '{1, 4, 0, 7, 16, 2};
        errors = 0;
        frames_taken = 0;
        quiet = 0;
        hold_done = 0;
        hold_left = 0;
        p_wlen = WL_RESET;
        clear_envelope();
        i_rst_n = 1'b0;
        frm.valid = 1'b0;
        frm.data = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;

        // reset window length: no window closes, so no energy
        add_frame(100, 200, -300, 400, 0);
        add_frame(5, 6, 7, 8, 1);
        // single-frame windows at the sample extremes
        add_cfg(1);
        add_frame(32767, 32767, -32768, -32768, 0);
        add_frame(-32768, -32768, 32767, 32767, 0);
        add_frame(32767, -32768, 1, -1, 1);
        // identical streams give full correlation
        add_frame(1000, 2000, 1000, 2000, 0);
        add_frame(-5, 9, -5, 9, 1);
        // all silent, and stream B alone silent
        add_frame(0, 0, 0, 0, 0);
        add_frame(0, 0, 0, 0, 1);
        add_frame(1234, -77, 0, 0, 1);
        // zero length acts as one
        add_cfg(0);
        add_frame(300, -300, 12, 13, 0);
        add_frame(-32768, 0, 0, 32767, 1);
        // longest window: trailing partial window is dropped
        add_cfg(65535);
        add_frame(32767, 32767, 32767, 32767, 0);
        add_frame(-32768, -32768, -32768, -32768, 1);
        // shortened window closes on the next frame
        add_cfg(8);
        for (int i = 0; i < 5; i++) add_frame(400 * i, 17, -90 * i, 3, 0);
        add_cfg(3);
        add_frame(2000, 2000, 100, -100, 0);
        add_frame(50, 60, 70, 80, 0);
        add_frame(-50, 60, -70, 80, 0);
        add_frame(9, 9, 9, 9, 1);

        foreach (wl_list[i]) begin
            add_cfg(wl_list[i]);
            add_streams(110, wl_list[i]);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !frm.valid && !cfg.valid && corr_q.size() == 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (errors == 0 && corr_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
